[design/kvt_pkg.sv]
package kvt_pkg;

  localparam int DATA_W       = 32;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int DEF_CAPACITY = 64;

  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] price;
  } entry_t;

  typedef enum logic [1:0] {
    RES_MID,
    RES_FINAL,
    RES_INSERT,
    RES_CLEAR
  } res_sel_t;

  typedef struct packed {
    logic     load_op;
    logic     start_scan;
    logic     advance;
    logic     capture;
    logic     load_shift;
    logic     shift_wr;
    logic     count_dec;
    logic     push;
    res_sel_t res_sel;
  } kvt_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic hit;
    logic pend_v;
    logic out_free;
  } kvt_sts_t;

endpackage

[design/kvt_ctrl.sv]
module kvt_ctrl
  import kvt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_stall,
  input  kvt_sts_t          sts,
  output kvt_cmd_t          cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic              is_query;

  assign is_query = (kind_r == KIND_QUERY);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.res_sel = RES_CLEAR;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_op = 1'b1;
          kind_nxt    = in_kind;
          case (in_kind)
            KIND_INSERT, KIND_CLEAR: state_nxt = S_FINISH;
            KIND_LOOKUP, KIND_REMOVE, KIND_QUERY: begin
              cmd.start_scan = 1'b1;
              state_nxt      = S_SCAN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (!sts.scan_end) begin
          if (!(is_query && sts.hit && sts.pend_v && !sts.out_free)) begin
            cmd.advance = 1'b1;
            cmd.capture = sts.hit;
            if (is_query && sts.hit && sts.pend_v) begin
              cmd.push    = 1'b1;
              cmd.res_sel = RES_MID;
            end
          end
        end else if (sts.out_free) begin
          cmd.push    = 1'b1;
          cmd.res_sel = RES_FINAL;
          if (kind_r == KIND_REMOVE && sts.pend_v) begin
            cmd.load_shift = 1'b1;
            state_nxt      = S_SHIFT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        if (!sts.scan_end) begin
          cmd.shift_wr = 1'b1;
          cmd.advance  = 1'b1;
        end else begin
          cmd.count_dec = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.push    = 1'b1;
          cmd.res_sel = (kind_r == KIND_INSERT) ? RES_INSERT : RES_CLEAR;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= KIND_INSERT;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

[design/kvt_dp.sv]
module kvt_dp
  import kvt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [KIND_W-1:0]          in_kind,
  input  logic signed [DATA_W-1:0]   in_key,
  input  logic signed [DATA_W-1:0]   in_price,
  input  logic signed [DATA_W-1:0]   in_range_low,
  input  logic signed [DATA_W-1:0]   in_range_high,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [DATA_W-1:0]   out_key,
  output logic signed [DATA_W-1:0]   out_price,
  output logic                       out_last,
  input  kvt_cmd_t                   cmd,
  output kvt_sts_t                   sts
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  entry_t            mem [CAPACITY];
  entry_t            rd_q_r;
  logic   [AW-1:0]   rd_addr;
  logic   [CW-1:0]   rd_addr_full;

  logic              query_r;
  logic [DATA_W-1:0] key_r, price_r, lo_r, hi_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     scan_r, scan_nxt, scan_dec;
  logic [CW-1:0]     pos_r, pos_inc;
  entry_t            pend_r;
  logic              pend_v_r;
  logic              full;
  logic              ins_wr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_key_r, out_key_nxt;
  logic [DATA_W-1:0]   out_price_r, out_price_nxt;
  logic                out_last_r, out_last_nxt;

  assign full     = (count_r == CW'(CAPACITY));
  assign pos_inc  = pos_r + CW'(1);
  assign scan_dec = scan_r - CW'(1);

  always_comb begin
    if (cmd.start_scan) begin
      scan_nxt = '0;
    end else if (cmd.load_shift) begin
      scan_nxt = pos_inc;
    end else if (cmd.advance) begin
      scan_nxt = scan_r + CW'(1);
    end else begin
      scan_nxt = scan_r;
    end
  end

  assign rd_addr_full = scan_nxt;
  assign rd_addr      = rd_addr_full[AW-1:0];

  assign sts.scan_end = (scan_r == count_r);
  assign sts.hit      = query_r ?
                        ($signed(rd_q_r.price) >= $signed(lo_r) &&
                         $signed(rd_q_r.price) <= $signed(hi_r)) :
                        (rd_q_r.key == key_r);
  assign sts.pend_v   = pend_v_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign ins_wr  = cmd.push && (cmd.res_sel == RES_INSERT) && !full;
  assign wr_en   = cmd.shift_wr || ins_wr;
  assign wr_addr = cmd.shift_wr ? scan_dec[AW-1:0] : count_r[AW-1:0];
  assign wr_data = cmd.shift_wr ? rd_q_r : entry_t'{key: key_r, price: price_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push && cmd.res_sel == RES_CLEAR) begin
      count_nxt = '0;
    end else if (ins_wr) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.count_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    out_status_nxt = ST_OK;
    out_key_nxt    = '0;
    out_price_nxt  = '0;
    out_last_nxt   = 1'b1;
    case (cmd.res_sel)
      RES_MID: begin
        out_key_nxt   = pend_r.key;
        out_price_nxt = pend_r.price;
        out_last_nxt  = 1'b0;
      end
      RES_FINAL: begin
        if (pend_v_r) begin
          out_key_nxt   = pend_r.key;
          out_price_nxt = pend_r.price;
        end else begin
          out_status_nxt = query_r ? ST_NO_MATCH : ST_NOT_FOUND;
        end
      end
      RES_INSERT: out_status_nxt = full ? ST_FULL : ST_OK;
      default:    out_status_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      query_r <= (in_kind == KIND_QUERY);
      key_r   <= in_key;
      price_r <= in_price;
      lo_r    <= in_range_low;
      hi_r    <= in_range_high;
    end
    scan_r <= scan_nxt;
    if (cmd.capture) begin
      pend_r <= rd_q_r;
      pos_r  <= scan_r;
    end
    if (cmd.push) begin
      out_status_r <= out_status_nxt;
      out_key_r    <= out_key_nxt;
      out_price_r  <= out_price_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.start_scan) begin
        pend_v_r <= 1'b0;
      end else if (cmd.capture) begin
        pend_v_r <= 1'b1;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_price  = out_price_r;
  assign out_last   = out_last_r;

endmodule

[design/compacting_key_value_table_unit.sv]
// Key/value table of up to CAPACITY entries, kept in insertion order.
// Input channel (in_valid/in_stall): one transaction carries a kind
// (insert, lookup, remove, clear, range query), a key, a price and the
// inclusive price bounds of a range query. Kinds 5 to 7 are dropped.
// Result channel (out_valid/out_stall): status, key, price and last; every
// input transaction except a dropped one yields results ending in last = 1.
// A range query yields one result per matching entry, or one no-match.
// One input is worked at a time; in_stall stays high until its results
// are all in the output register and, for a remove, the gap is closed.
// Insert and clear pass to a finish state that pushes their result.
// Lookup and range query read each stored entry from the entry memory in
// turn; remove then moves each later entry down one place to close the gap.
// A stalled receiver holds the output register; a range query then pauses
// its scan at a match while two earlier matches still wait.
// Reset empties the table at once; no clearing pass is needed.
module compacting_key_value_table_unit
  import kvt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [DATA_W-1:0] in_key,
  input  logic signed [DATA_W-1:0] in_price,
  input  logic signed [DATA_W-1:0] in_range_low,
  input  logic signed [DATA_W-1:0] in_range_high,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_key,
  output logic signed [DATA_W-1:0] out_price,
  output logic                     out_last
);

  kvt_cmd_t cmd;
  kvt_sts_t sts;

  kvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kvt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_kind       (in_kind),
    .in_key        (in_key),
    .in_price      (in_price),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_key       (out_key),
    .out_price     (out_price),
    .out_last      (out_last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
